@@ rtl/core/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg: shared types and constants of the indexed array list
// Widths, request codes, transfer payloads and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ial_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned TYPE_W    = 2;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CNT_W-1:0]   CAPACITY_RST = CNT_W'(64);

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [TYPE_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [TYPE_W-1:0]        req_type;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  typedef struct packed {
    logic req_load;
    logic ok_load;
    logic ptr_load;
    logic ptr_step;
    logic mem_rd;
    logic mem_shift_wr;
    logic mem_val_wr;
    logic cnt_inc;
    logic cnt_dec;
    logic rsp_load;
  } dp_cmd_t;

  typedef struct packed {
    req_type_e kind;
    logic      ok;
    logic      shift_done;
  } dp_sts_t;

endpackage

@@ rtl/core/ial_chan_if.sv @@
// ----------------------------------------------------------------------------
// ial_chan_if: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ial_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

@@ rtl/core/ial_regs.sv @@
// ----------------------------------------------------------------------------
// ial_regs: configuration register file
// APB-style access to the capacity register; writes complete in the access
// phase, pready is tied high.
// ----------------------------------------------------------------------------
module ial_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ial_pkg::PADDR_W-1:0] paddr,
  input  logic [ial_pkg::PDATA_W-1:0] pwdata,
  output logic [ial_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [ial_pkg::CNT_W-1:0]   capacity_o
);
  import ial_pkg::*;

  logic [CNT_W-1:0] capacity_q;
  logic             hit_cap;

  assign hit_cap    = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign pready     = 1'b1;
  assign capacity_o = capacity_q;
  assign prdata     = hit_cap ? PDATA_W'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RST;
    end else if (psel && penable && pwrite && pready && hit_cap) begin
      capacity_q <= pwdata[CNT_W-1:0];
    end
  end

endmodule

@@ rtl/core/ial_dp.sv @@
// ----------------------------------------------------------------------------
// ial_dp: list datapath
// Entry memory with one write and one registered read port, entry count,
// shift pointer, request and result registers.
// ----------------------------------------------------------------------------
module ial_dp #(
  parameter int unsigned DEPTH = ial_pkg::DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ial_pkg::req_t             req_i,
  input  logic [ial_pkg::CNT_W-1:0] capacity_i,
  input  ial_pkg::dp_cmd_t          cmd_i,
  output ial_pkg::dp_sts_t          sts_o,
  output ial_pkg::rsp_t             rsp_o
);
  import ial_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  req_type_e         kind_q;
  logic [CNT_W-1:0]  idx_q;
  logic [DATA_W-1:0] val_q;
  logic              ok_q;
  logic [CNT_W-1:0]  ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  rsp_t              rsp_q;

  logic              room;
  logic              ok_c;
  logic [CNT_W:0]    ptr_inc;
  logic [CNT_W-1:0]  src_c;
  logic [CNT_W-1:0]  rd_addr_c;
  logic [CNT_W-1:0]  wr_addr_c;
  logic [DATA_W-1:0] wr_data_c;
  logic              wr_en;

  assign room = (cnt_q < capacity_i) && (32'(cnt_q) < DEPTH);

  always_comb begin
    case (kind_q)
      REQ_APPEND: ok_c = room;
      REQ_INSERT: ok_c = room && (idx_q <= cnt_q);
      REQ_DELETE: ok_c = (idx_q < cnt_q);
      REQ_READ:   ok_c = (idx_q < cnt_q);
      default:    ok_c = 1'b0;
    endcase
  end

  assign ptr_inc   = {1'b0, ptr_q} + 1'b1;
  assign src_c     = (kind_q == REQ_INSERT) ? (ptr_q - 1'b1) : ptr_inc[CNT_W-1:0];
  assign rd_addr_c = (kind_q == REQ_READ) ? idx_q : src_c;
  assign wr_en     = cmd_i.mem_shift_wr || cmd_i.mem_val_wr;
  assign wr_addr_c = cmd_i.mem_shift_wr ? ptr_q :
                     ((kind_q == REQ_APPEND) ? cnt_q : idx_q);
  assign wr_data_c = cmd_i.mem_shift_wr ? rd_data_q : val_q;

  assign sts_o.kind       = kind_q;
  assign sts_o.ok         = ok_c;
  assign sts_o.shift_done = (kind_q == REQ_INSERT) ? (ptr_q == idx_q)
                                                   : (ptr_inc >= {1'b0, cnt_q});
  assign rsp_o            = rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(wr_addr_c)] <= wr_data_c;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[AW'(rd_addr_c)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      kind_q <= req_type_e'(req_i.req_type);
      idx_q  <= CNT_W'(req_i.index);
      val_q  <= req_i.value;
    end
    if (cmd_i.ok_load) begin
      ok_q <= ok_c;
    end
    if (cmd_i.ptr_load) begin
      ptr_q <= (kind_q == REQ_INSERT) ? cnt_q : idx_q;
    end else if (cmd_i.ptr_step) begin
      ptr_q <= (kind_q == REQ_INSERT) ? (ptr_q - 1'b1) : ptr_inc[CNT_W-1:0];
    end
    if (cmd_i.rsp_load) begin
      rsp_q.status     <= ok_q ? STATUS_OK : STATUS_REJECT;
      rsp_q.count      <= cnt_q;
      rsp_q.read_value <= (ok_q && (kind_q == REQ_READ)) ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ rtl/core/ial_ctrl.sv @@
// ----------------------------------------------------------------------------
// ial_ctrl: list controller
// Sequences each request: check, entry shift one move at a time, value
// write, count update and result hand-off.
// ----------------------------------------------------------------------------
module ial_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ial_pkg::dp_sts_t  sts_i,
  output ial_pkg::dp_cmd_t  cmd_o
);
  import ial_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT_CHK,
    ST_SHIFT_WR,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.ok_load  = 1'b1;
        cmd_o.ptr_load = 1'b1;
        state_d        = ST_FINISH;
        if (sts_i.ok) begin
          case (sts_i.kind)
            REQ_APPEND: begin
              cmd_o.mem_val_wr = 1'b1;
              cmd_o.cnt_inc    = 1'b1;
            end
            REQ_READ: begin
              cmd_o.mem_rd = 1'b1;
            end
            default: begin
              state_d = ST_SHIFT_CHK;
            end
          endcase
        end
      end
      ST_SHIFT_CHK: begin
        if (sts_i.shift_done) begin
          if (sts_i.kind == REQ_INSERT) begin
            cmd_o.mem_val_wr = 1'b1;
            cmd_o.cnt_inc    = 1'b1;
          end else begin
            cmd_o.cnt_dec = 1'b1;
          end
          state_d = ST_FINISH;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd_o.mem_shift_wr = 1'b1;
        cmd_o.ptr_step     = 1'b1;
        state_d            = ST_SHIFT_CHK;
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.rsp_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/core/indexed_array_list_core.sv @@
// Result of append, read or a rejected request: ST_EXEC, then ST_FINISH.
// Insert or delete: ST_SHIFT_CHK and ST_SHIFT_WR between them for each of n
// entries moved (count-index for insert, count-index-1 for delete); each move
// is a read of the entry memory in ST_SHIFT_CHK and a write in ST_SHIFT_WR.
// The result is registered in ST_FINISH once the output slot is free; the next
// transfer is taken the cycle after the result is registered.
// Reset: count 0, capacity 64; entry memory is not cleared.
// ----------------------------------------------------------------------------
// indexed_array_list_core: ordered list of signed words
// Append, insert, delete and read on a list held in an entry memory, with a
// configurable capacity register.
// ----------------------------------------------------------------------------
module indexed_array_list_core #(
  parameter int unsigned DEPTH = ial_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ial_chan_if.sink                    req_i,
  ial_chan_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ial_pkg::PADDR_W-1:0] paddr,
  input  logic [ial_pkg::PDATA_W-1:0] pwdata,
  output logic [ial_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ial_pkg::*;

  logic [CNT_W-1:0] capacity;
  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;

  ial_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  ial_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (dp_sts),
    .cmd_o       (dp_cmd)
  );

  ial_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i.data),
    .capacity_i (capacity),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .rsp_o      (rsp_o.data)
  );

`ifndef ASSERT_OFF
  a_count_in_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (32'(rsp_o.data.count) <= DEPTH))
    else $error("result count above depth");

  a_shift_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.mem_shift_wr |-> !req_i.ready)
    else $error("entry shift while a request can be taken");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.rsp_load |=> rsp_o.valid)
    else $error("loaded result not presented");

  a_read_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.data.read_value != '0)) |-> (rsp_o.data.status == STATUS_OK))
    else $error("nonzero read value on a rejected request");
`endif

endmodule
